@@ rtl/core/lzd_pkg.sv @@
// Shared constants and types for the LZ10/LZ11 stream decompressor.
`timescale 1ns / 1ps

package lzd_pkg;

   // Sliding window geometry
   localparam int unsigned WINDOW_DEPTH = 4096;
   localparam int unsigned WIN_AW       = $clog2(WINDOW_DEPTH);

   // Stream format type bytes
   localparam logic [7:0] TYPE_LZ10 = 8'h10;
   localparam logic [7:0] TYPE_LZ11 = 8'h11;

   // LZ10 and LZ11 length offsets
   localparam logic [16:0] LZ11_ADD_MID  = 17'h00011;
   localparam logic [16:0] LZ11_ADD_LONG = 17'h00111;
   localparam logic [16:0] LZ10_ADD      = 17'd3;

   // Request opcodes
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   // Response kinds
   localparam logic [1:0] KIND_DATA      = 2'd0;
   localparam logic [1:0] KIND_BAD_TYPE  = 2'd1;
   localparam logic [1:0] KIND_MISPLACED = 2'd2;
   localparam logic [1:0] KIND_EMPTY     = 2'd3;

   // Parser phase codes
   localparam logic [3:0] PH_TYPE  = 4'd0;
   localparam logic [3:0] PH_SIZE0 = 4'd1;
   localparam logic [3:0] PH_SIZE1 = 4'd2;
   localparam logic [3:0] PH_SIZE2 = 4'd3;
   localparam logic [3:0] PH_EXT0  = 4'd4;
   localparam logic [3:0] PH_EXT1  = 4'd5;
   localparam logic [3:0] PH_EXT2  = 4'd6;
   localparam logic [3:0] PH_EXT3  = 4'd7;
   localparam logic [3:0] PH_FLAGS = 4'd8;
   localparam logic [3:0] PH_ITEM  = 4'd9;
   localparam logic [3:0] PH_COPY  = 4'd10;
   localparam logic [3:0] PH_DONE  = 4'd11;
   localparam logic [3:0] PH_ERROR = 4'd12;

   // Source of the byte value resolved in the second stage
   localparam logic [1:0] SEL_LIT  = 2'd0;
   localparam logic [1:0] SEL_RAM  = 2'd1;
   localparam logic [1:0] SEL_ZERO = 2'd2;

   // Entry held between parse stage and output register
   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        sel;
      logic              fwd;
      logic [7:0]        lit;
      logic              last;
      logic              pend;
      logic              we;
      logic [WIN_AW-1:0] waddr;
   } s2_type;

endpackage

@@ rtl/core/lzd_req_if.sv @@
// Request channel interface: opcode and compressed byte.
`timescale 1ns / 1ps

interface lzd_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] in_byte;

   modport source (output valid, output op, output in_byte, input ready);
   modport sink   (input valid, input op, input in_byte, output ready);
endinterface

@@ rtl/core/lzd_rsp_if.sv @@
// Response channel interface: result kind, data byte and flags.
`timescale 1ns / 1ps

interface lzd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic       last;
   logic       copy_pending;

   modport source (output valid, output kind, output out_byte, output last,
                   output copy_pending, input ready);
   modport sink   (input valid, input kind, input out_byte, input last,
                   input copy_pending, output ready);
endinterface

@@ rtl/core/lzd_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module lzd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read returns old contents on a same-address collision
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/lz10_lz11_stream_decompressor_unit.sv @@
// LZ10/LZ11 decompressor top level: stream parser, window RAM and output stage.
//
// Usage: each request carries op and in_byte. op = byte feeds one compressed
// stream byte (type, size, flag, literal or match token byte). op = advance
// asks for the next byte of a pending match copy. Each request gives zero or
// one response: a data byte (last marks the final one, copy_pending says more
// advance requests are due), a bad-type error, a misplaced-request error or an
// empty-stream notice. After an error every request answers misplaced.
// A response reaches rsp_ch after its request is taken by passing stage two
// and then the output register.
// Throughput: one request per cycle unless rsp_ch stalls; the parse stage
// issues one window read per request and the byte it yields is written back
// as stage two retires, with a forwarding path covering a match distance of one.
// Reset (synchronous) returns the parser to the type byte; the window RAM is
// not cleared, and bytes before the first output read as zero by distance
// check. When rsp_ch stalls, the output register holds, the second stage
// fills, and req_ch.ready drops until the output register frees.
`timescale 1ns / 1ps

module lz10_lz11_stream_decompressor_unit (
   input  logic       clock,
   input  logic       reset,
   lzd_req_if.sink    req_ch,
   lzd_rsp_if.source  rsp_ch
);

   // Parser state
   logic [3:0]                    phase_ff, phase_in;
   logic                          lz11_ff, lz11_in;
   logic [31:0]                   target_ff, target_in;
   logic [31:0]                   prod_ff, prod_in;
   logic [7:0]                    flags_ff, flags_in;
   logic [3:0]                    fidx_ff, fidx_in;
   logic [23:0]                   tok_ff, tok_in;
   logic [1:0]                    tcnt_ff, tcnt_in;
   logic [16:0]                   rem_ff, rem_in;
   logic [12:0]                   dist_ff, dist_in;
   logic [lzd_pkg::WIN_AW-1:0]    wp_ff, wp_in;

   // Pipeline registers
   logic                          s2_valid_ff, s2_valid_in;
   lzd_pkg::s2_type               s2_ff, s2_in;
   logic [7:0]                    fwd_data_ff;
   logic                          out_valid_ff, out_valid_in;
   logic [1:0]                    out_kind_ff;
   logic [7:0]                    out_byte_ff;
   logic                          out_last_ff;
   logic                          out_pend_ff;

   // Parse-stage working signals
   logic                          req_fire;
   logic                          s2_adv;
   logic                          res_valid;
   logic [lzd_pkg::WIN_AW-1:0]    raddr;
   logic [7:0]                    b;
   logic [7:0]                    b0;
   logic [3:0]                    nib;
   logic [2:0]                    need;
   logic [31:0]                   v;
   logic [16:0]                   len;
   logic [31:0]                   prod_inc;
   logic                          push_last;
   logic                          do_copy;
   logic                          do_fail;
   logic [1:0]                    fail_kind;
   logic [12:0]                   cp_dist;
   logic [16:0]                   cp_rem;
   logic [16:0]                   rem_dec;
   logic                          flag_bit;
   logic                          after_done;
   logic [3:0]                    after_phase;
   logic [7:0]                    ram_rdata;
   logic [7:0]                    s2_value;

   // Handshake
   assign s2_adv       = s2_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s2_valid_ff || s2_adv;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign b            = req_ch.in_byte;

   // Shared push arithmetic
   assign prod_inc  = prod_ff + 32'd1;
   assign push_last = (prod_inc == target_ff);
   assign flag_bit  = flags_ff[3'd7 - fidx_ff[2:0]];

   // First byte of the current match token
   always_comb begin
      case (tcnt_ff)
         2'd0:    b0 = b;
         2'd1:    b0 = tok_ff[7:0];
         2'd2:    b0 = tok_ff[15:8];
         default: b0 = tok_ff[23:16];
      endcase
   end

   // Token size and decoded length
   assign nib = b0[7:4];
   assign v   = {tok_ff, b};

   always_comb begin
      if (!lz11_ff) begin
         need = 3'd2;
         len  = {13'd0, v[15:12]} + lzd_pkg::LZ10_ADD;
      end else if (nib == 4'd0) begin
         need = 3'd3;
         len  = {9'd0, v[19:12]} + lzd_pkg::LZ11_ADD_MID;
      end else if (nib == 4'd1) begin
         need = 3'd4;
         len  = {1'b0, v[27:12]} + lzd_pkg::LZ11_ADD_LONG;
      end else begin
         need = 3'd2;
         len  = {13'd0, nib} + 17'd1;
      end
   end

   // Parse stage: next state and response entry
   always_comb begin
      phase_in  = phase_ff;
      lz11_in   = lz11_ff;
      target_in = target_ff;
      prod_in   = prod_ff;
      flags_in  = flags_ff;
      fidx_in   = fidx_ff;
      tok_in    = tok_ff;
      tcnt_in   = tcnt_ff;
      rem_in    = rem_ff;
      dist_in   = dist_ff;
      wp_in     = wp_ff;

      res_valid = 1'b0;
      s2_in       = '0;
      s2_in.kind  = lzd_pkg::KIND_DATA;
      s2_in.sel   = lzd_pkg::SEL_LIT;
      s2_in.lit   = b;
      s2_in.waddr = wp_ff;

      do_copy   = 1'b0;
      do_fail   = 1'b0;
      fail_kind = lzd_pkg::KIND_MISPLACED;
      cp_dist   = dist_ff;
      cp_rem    = rem_ff;
      raddr     = wp_ff;
      rem_dec   = 17'd0;

      if (req_fire) begin
         if (phase_ff == lzd_pkg::PH_ERROR || phase_ff == lzd_pkg::PH_DONE) begin
            do_fail = 1'b1;
         end else if (phase_ff == lzd_pkg::PH_COPY) begin
            if (req_ch.op != lzd_pkg::OP_ADVANCE) begin
               do_fail = 1'b1;
            end else begin
               do_copy = 1'b1;
            end
         end else if (req_ch.op != lzd_pkg::OP_BYTE) begin
            do_fail = 1'b1;
         end else begin
            case (phase_ff)
               lzd_pkg::PH_TYPE: begin
                  if (b != lzd_pkg::TYPE_LZ10 && b != lzd_pkg::TYPE_LZ11) begin
                     do_fail   = 1'b1;
                     fail_kind = lzd_pkg::KIND_BAD_TYPE;
                  end else begin
                     lz11_in   = (b == lzd_pkg::TYPE_LZ11);
                     target_in = 32'd0;
                     phase_in  = lzd_pkg::PH_SIZE0;
                  end
               end
               lzd_pkg::PH_SIZE0: begin
                  target_in[7:0] = b;
                  phase_in       = lzd_pkg::PH_SIZE1;
               end
               lzd_pkg::PH_SIZE1: begin
                  target_in[15:8] = b;
                  phase_in        = lzd_pkg::PH_SIZE2;
               end
               lzd_pkg::PH_SIZE2: begin
                  target_in[23:16] = b;
                  phase_in = (target_in == 32'd0) ? lzd_pkg::PH_EXT0 : lzd_pkg::PH_FLAGS;
               end
               lzd_pkg::PH_EXT0: begin
                  target_in[7:0] = b;
                  phase_in       = lzd_pkg::PH_EXT1;
               end
               lzd_pkg::PH_EXT1: begin
                  target_in[15:8] = b;
                  phase_in        = lzd_pkg::PH_EXT2;
               end
               lzd_pkg::PH_EXT2: begin
                  target_in[23:16] = b;
                  phase_in         = lzd_pkg::PH_EXT3;
               end
               lzd_pkg::PH_EXT3: begin
                  target_in[31:24] = b;
                  if (target_in == 32'd0) begin
                     // Empty stream: notify and finish
                     phase_in   = lzd_pkg::PH_DONE;
                     res_valid  = 1'b1;
                     s2_in.kind = lzd_pkg::KIND_EMPTY;
                     s2_in.sel  = lzd_pkg::SEL_ZERO;
                  end else begin
                     phase_in = lzd_pkg::PH_FLAGS;
                  end
               end
               lzd_pkg::PH_FLAGS: begin
                  flags_in = b;
                  fidx_in  = 4'd0;
                  tcnt_in  = 2'd0;
                  tok_in   = 24'd0;
                  phase_in = lzd_pkg::PH_ITEM;
               end
               default: begin
                  if (!flag_bit) begin
                     // Literal byte
                     res_valid  = 1'b1;
                     s2_in.last = push_last;
                     s2_in.we   = 1'b1;
                     prod_in    = prod_inc;
                     wp_in      = wp_ff + 1'b1;
                     fidx_in    = fidx_ff + 4'd1;
                  end else if ({1'b0, tcnt_ff} + 3'd1 < need) begin
                     // Collect further token bytes
                     tok_in  = {tok_ff[15:0], b};
                     tcnt_in = tcnt_ff + 2'd1;
                  end else begin
                     // Token complete: start the match
                     tok_in  = 24'd0;
                     tcnt_in = 2'd0;
                     cp_dist = {1'b0, v[11:0]} + 13'd1;
                     cp_rem  = len;
                     fidx_in = fidx_ff + 4'd1;
                     do_copy = 1'b1;
                  end
               end
            endcase
         end
      end

      // Phase after a finished literal or match
      after_done = (prod_in == target_ff);
      if (after_done) begin
         after_phase = lzd_pkg::PH_DONE;
      end else if (fidx_in >= 4'd8) begin
         after_phase = lzd_pkg::PH_FLAGS;
      end else begin
         after_phase = lzd_pkg::PH_ITEM;
      end

      if (req_fire && !do_fail && !do_copy && res_valid && s2_in.we) begin
         phase_in = after_phase;
      end

      // One match byte from the window
      if (do_copy) begin
         res_valid  = 1'b1;
         raddr      = wp_ff - cp_dist[lzd_pkg::WIN_AW-1:0];
         s2_in.sel  = ({19'd0, cp_dist} <= prod_ff && cp_dist != 13'd0) ?
                      lzd_pkg::SEL_RAM : lzd_pkg::SEL_ZERO;
         s2_in.fwd  = s2_adv && s2_ff.we && (s2_ff.waddr == raddr);
         s2_in.last = push_last;
         s2_in.we   = 1'b1;
         prod_in    = prod_inc;
         wp_in      = wp_ff + 1'b1;
         dist_in    = cp_dist;
         rem_dec    = cp_rem - 17'd1;
         rem_in     = rem_dec;
         if (push_last) begin
            rem_in   = 17'd0;
            phase_in = lzd_pkg::PH_DONE;
         end else if (rem_dec == 17'd0) begin
            phase_in = after_phase;
         end else begin
            phase_in   = lzd_pkg::PH_COPY;
            s2_in.pend = 1'b1;
         end
      end

      // Error response; state is sticky until reset
      if (do_fail) begin
         phase_in   = lzd_pkg::PH_ERROR;
         rem_in     = 17'd0;
         res_valid  = 1'b1;
         s2_in      = '0;
         s2_in.kind = fail_kind;
         s2_in.sel  = lzd_pkg::SEL_ZERO;
      end
   end

   // Second stage occupancy
   assign s2_valid_in = (req_fire && res_valid) ? 1'b1 : (s2_valid_ff && !s2_adv);

   // Resolve the response byte
   always_comb begin
      case (s2_ff.sel)
         lzd_pkg::SEL_LIT: s2_value = s2_ff.lit;
         lzd_pkg::SEL_RAM: s2_value = s2_ff.fwd ? fwd_data_ff : ram_rdata;
         default:          s2_value = 8'd0;
      endcase
   end

   // Output register occupancy
   assign out_valid_in = s2_adv ? 1'b1 : (out_valid_ff && !rsp_ch.ready);

   // Window RAM: read in parse stage, write-back as stage two retires
   lzd_ram #(
      .WIDTH (8),
      .DEPTH (lzd_pkg::WINDOW_DEPTH)
   ) u_window (
      .clock (clock),
      .we    (s2_adv && s2_ff.we),
      .waddr (s2_ff.waddr),
      .wdata (s2_value),
      .re    (req_fire),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lzd_pkg::PH_TYPE;
         lz11_ff      <= 1'b0;
         target_ff    <= 32'd0;
         prod_ff      <= 32'd0;
         flags_ff     <= 8'd0;
         fidx_ff      <= 4'd0;
         tok_ff       <= 24'd0;
         tcnt_ff      <= 2'd0;
         rem_ff       <= 17'd0;
         dist_ff      <= 13'd0;
         wp_ff        <= '0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         lz11_ff      <= lz11_in;
         target_ff    <= target_in;
         prod_ff      <= prod_in;
         flags_ff     <= flags_in;
         fidx_ff      <= fidx_in;
         tok_ff       <= tok_in;
         tcnt_ff      <= tcnt_in;
         rem_ff       <= rem_in;
         dist_ff      <= dist_in;
         wp_ff        <= wp_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire && res_valid) begin
         s2_ff <= s2_in;
      end
      if (s2_adv) begin
         fwd_data_ff <= s2_value;
         out_kind_ff <= s2_ff.kind;
         out_byte_ff <= s2_value;
         out_last_ff <= s2_ff.last;
         out_pend_ff <= s2_ff.pend;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.kind         = out_kind_ff;
   assign rsp_ch.out_byte     = out_byte_ff;
   assign rsp_ch.last         = out_last_ff;
   assign rsp_ch.copy_pending = out_pend_ff;

   // Checks
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == lzd_pkg::PH_ERROR |=> phase_ff == lzd_pkg::PH_ERROR)
      else $error("error phase left without reset");

   a_copy_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == lzd_pkg::PH_COPY |-> rem_ff != 17'd0)
      else $error("copy phase with no bytes remaining");

   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_adv |=> s2_valid_ff)
      else $error("stage two entry dropped while stalled");

   a_nondata_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff != lzd_pkg::KIND_DATA |->
         out_byte_ff == 8'd0 && !out_last_ff && !out_pend_ff)
      else $error("status response carries data flags");

endmodule
